// ===== hdl/afr_pkg.sv =====
// ----------------------------------------------------------------------------
// afr_pkg
// Shared types and constants of the API frame receiver: parse stages,
// byte operation codes passed from front to back, and the queue entry.
// ----------------------------------------------------------------------------
package afr_pkg;

	localparam logic [7:0]  START_DELIM  = 8'h7E;
	localparam logic [7:0]  GOOD_SUM     = 8'hFF;
	localparam logic [15:0] HEADER_BYTES = 16'd5;
	localparam int          QUEUE_DEPTH  = 4;

	localparam logic RESULT_PAYLOAD   = 1'b0;
	localparam logic RESULT_FRAME_END = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_TYPE,
		ST_IDENT,
		ST_ADDR_HI,
		ST_ADDR_LO,
		ST_SKIP,
		ST_PAYLOAD,
		ST_CHECK
	} stage_t;

	typedef enum logic [2:0] {
		OP_TYPE,
		OP_IDENT,
		OP_ADDR_HI,
		OP_ADDR_LO,
		OP_SKIP,
		OP_PAYLOAD,
		OP_CHECK
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  data;
		logic        last;
		logic [15:0] plen;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t entry;
	} push_t;

endpackage

// ===== hdl/afr_front.sv =====
// ----------------------------------------------------------------------------
// afr_front
// Front end: tracks the frame stage, reads the length field, counts payload
// bytes and tags every byte after the length with an operation for the back.
// ----------------------------------------------------------------------------
module afr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                q_full,
	input  logic [7:0]          rx_byte,
	output afr_pkg::push_t      q_push
);

	afr_pkg::stage_t stage_q, stage_d;
	logic [15:0] length_word_q, length_word_d;
	logic [15:0] bytes_left_q, bytes_left_d;
	logic [15:0] plen;
	logic        accept;

	assign accept = in_valid && !q_full;
	// payload count, length minus header, floored at zero
	assign plen = (length_word_q <= afr_pkg::HEADER_BYTES) ? 16'd0
		: length_word_q - afr_pkg::HEADER_BYTES;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q       <= afr_pkg::ST_IDLE;
			length_word_q <= '0;
			bytes_left_q  <= '0;
		end else begin
			stage_q       <= stage_d;
			length_word_q <= length_word_d;
			bytes_left_q  <= bytes_left_d;
		end
	end

	always_comb begin
		stage_d            = stage_q;
		length_word_d      = length_word_q;
		bytes_left_d       = bytes_left_q;
		q_push.push        = 1'b0;
		q_push.entry.op    = afr_pkg::OP_SKIP;
		q_push.entry.data  = rx_byte;
		q_push.entry.last  = 1'b0;
		q_push.entry.plen  = plen;
		if (accept) begin
			case (stage_q)
				afr_pkg::ST_LEN_HI: begin
					length_word_d = {rx_byte, 8'h00};
					stage_d       = afr_pkg::ST_LEN_LO;
				end
				afr_pkg::ST_LEN_LO: begin
					length_word_d = {length_word_q[15:8], rx_byte};
					stage_d       = afr_pkg::ST_TYPE;
				end
				afr_pkg::ST_TYPE: begin
					q_push.push     = 1'b1;
					q_push.entry.op = afr_pkg::OP_TYPE;
					stage_d         = afr_pkg::ST_IDENT;
				end
				afr_pkg::ST_IDENT: begin
					q_push.push     = 1'b1;
					q_push.entry.op = afr_pkg::OP_IDENT;
					stage_d         = afr_pkg::ST_ADDR_HI;
				end
				afr_pkg::ST_ADDR_HI: begin
					q_push.push     = 1'b1;
					q_push.entry.op = afr_pkg::OP_ADDR_HI;
					stage_d         = afr_pkg::ST_ADDR_LO;
				end
				afr_pkg::ST_ADDR_LO: begin
					q_push.push     = 1'b1;
					q_push.entry.op = afr_pkg::OP_ADDR_LO;
					stage_d         = afr_pkg::ST_SKIP;
				end
				afr_pkg::ST_SKIP: begin
					q_push.push     = 1'b1;
					q_push.entry.op = afr_pkg::OP_SKIP;
					bytes_left_d    = plen;
					stage_d = (plen == 16'd0) ? afr_pkg::ST_CHECK : afr_pkg::ST_PAYLOAD;
				end
				afr_pkg::ST_PAYLOAD: begin
					q_push.push       = 1'b1;
					q_push.entry.op   = afr_pkg::OP_PAYLOAD;
					q_push.entry.last = (bytes_left_q <= 16'd1);
					if (bytes_left_q <= 16'd1) begin
						bytes_left_d = '0;
						stage_d      = afr_pkg::ST_CHECK;
					end else begin
						bytes_left_d = bytes_left_q - 16'd1;
					end
				end
				afr_pkg::ST_CHECK: begin
					q_push.push     = 1'b1;
					q_push.entry.op = afr_pkg::OP_CHECK;
					stage_d         = afr_pkg::ST_IDLE;
				end
				default: begin
					// hunting for the start delimiter, other bytes dropped
					stage_d = (rx_byte == afr_pkg::START_DELIM) ? afr_pkg::ST_LEN_HI
						: afr_pkg::ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_payload_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_q == afr_pkg::ST_PAYLOAD) |-> (bytes_left_q != 16'd0))
		else $error("payload stage with no bytes left");
`endif

endmodule

// ===== hdl/afr_queue.sv =====
// ----------------------------------------------------------------------------
// afr_queue
// Small FIFO of tagged bytes between the front end and the back end.
// ----------------------------------------------------------------------------
module afr_queue #(
	parameter int DEPTH = afr_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  afr_pkg::push_t  q_push,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output afr_pkg::entry_t rd_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	afr_pkg::entry_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push, do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign push      = q_push.push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= q_push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a write");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count did not follow a read");
`endif

endmodule

// ===== hdl/afr_back.sv =====
// ----------------------------------------------------------------------------
// afr_back
// Back end: captures header fields, keeps the running checksum and loads
// payload and frame-end results into the output register.
// ----------------------------------------------------------------------------
module afr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_not_empty,
	input  afr_pkg::entry_t q_entry,
	output logic            q_pop,
	input  logic            out_stall,
	output logic            out_valid,
	output logic            result_kind,
	output logic [7:0]      payload_byte,
	output logic            last_payload,
	output logic [7:0]      frame_type,
	output logic [7:0]      frame_ident,
	output logic [15:0]     source_address,
	output logic [15:0]     payload_length,
	output logic            checksum_ok
);

	logic [7:0]  running_sum_q, sum_next;
	logic [7:0]  held_type_q, held_ident_q;
	logic [15:0] held_address_q;

	logic        out_valid_q;
	logic        result_kind_q, last_payload_q, checksum_ok_q;
	logic [7:0]  payload_byte_q, frame_type_q, frame_ident_q;
	logic [15:0] source_address_q, payload_length_q;

	logic        emits;

	// output register free or being emptied this cycle
	assign q_pop    = q_not_empty && (!out_valid_q || !out_stall);
	assign sum_next = running_sum_q + q_entry.data;
	assign emits    = (q_entry.op == afr_pkg::OP_PAYLOAD) || (q_entry.op == afr_pkg::OP_CHECK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q  <= '0;
			held_type_q    <= '0;
			held_ident_q   <= '0;
			held_address_q <= '0;
		end else if (q_pop) begin
			case (q_entry.op)
				afr_pkg::OP_TYPE: begin
					// sum restarts with the first byte after the length
					held_type_q   <= q_entry.data;
					running_sum_q <= q_entry.data;
				end
				afr_pkg::OP_IDENT: begin
					held_ident_q  <= q_entry.data;
					running_sum_q <= sum_next;
				end
				afr_pkg::OP_ADDR_HI: begin
					held_address_q <= {q_entry.data, 8'h00};
					running_sum_q  <= sum_next;
				end
				afr_pkg::OP_ADDR_LO: begin
					held_address_q <= {held_address_q[15:8], q_entry.data};
					running_sum_q  <= sum_next;
				end
				afr_pkg::OP_SKIP, afr_pkg::OP_PAYLOAD: begin
					running_sum_q <= sum_next;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop && emits) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emits) begin
			if (q_entry.op == afr_pkg::OP_CHECK) begin
				result_kind_q    <= afr_pkg::RESULT_FRAME_END;
				payload_byte_q   <= '0;
				last_payload_q   <= 1'b0;
				frame_type_q     <= held_type_q;
				frame_ident_q    <= held_ident_q;
				source_address_q <= held_address_q;
				payload_length_q <= q_entry.plen;
				checksum_ok_q    <= (sum_next == afr_pkg::GOOD_SUM);
			end else begin
				result_kind_q    <= afr_pkg::RESULT_PAYLOAD;
				payload_byte_q   <= q_entry.data;
				last_payload_q   <= q_entry.last;
				frame_type_q     <= '0;
				frame_ident_q    <= '0;
				source_address_q <= '0;
				payload_length_q <= '0;
				checksum_ok_q    <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = result_kind_q;
	assign payload_byte   = payload_byte_q;
	assign last_payload   = last_payload_q;
	assign frame_type     = frame_type_q;
	assign frame_ident    = frame_ident_q;
	assign source_address = source_address_q;
	assign payload_length = payload_length_q;
	assign checksum_ok    = checksum_ok_q;

`ifndef SYNTHESIS
	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (result_kind_q == afr_pkg::RESULT_FRAME_END))
		|-> (!last_payload_q && (payload_byte_q == 8'h00)))
		else $error("frame-end result carries payload bits");
`endif

endmodule

// ===== hdl/api_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// api_frame_receiver
// Input channel: one link byte per transfer on rx_byte (in_valid/in_stall).
// The block waits for the 0x7E delimiter, reads a big-endian length, type,
// identifier, source address and one spare byte, then length-5 payload bytes
// and a checksum byte.
// Output channel (out_valid/out_stall): one transfer per payload byte with
// result_kind 0 and last_payload on the final one, and one frame-end transfer
// with result_kind 1 carrying the header fields and checksum_ok.
// Throughput: one byte per cycle while the tag queue has room. The byte that
// causes a result is written to the queue, then into the output register.
// The front end stalls the input only when its tag queue is full, which
// happens when the receiver holds out_stall; header and length bytes keep
// flowing while the queue has room.
// Reset clears the parse stage, queue and output valid; the block then hunts
// for a start delimiter.
// ----------------------------------------------------------------------------
module api_frame_receiver #(
	parameter int QUEUE_DEPTH = afr_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [7:0]  payload_byte,
	output logic        last_payload,
	output logic [7:0]  frame_type,
	output logic [7:0]  frame_ident,
	output logic [15:0] source_address,
	output logic [15:0] payload_length,
	output logic        checksum_ok
);

	afr_pkg::push_t  q_push;
	afr_pkg::entry_t q_entry;
	logic            q_full, q_not_empty, q_pop;

	assign in_stall = q_full;

	afr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.q_full  (q_full),
		.rx_byte (rx_byte),
		.q_push  (q_push)
	);

	afr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_push   (q_push),
		.pop      (q_pop),
		.full     (q_full),
		.not_empty(q_not_empty),
		.rd_entry (q_entry)
	);

	afr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.q_entry       (q_entry),
		.q_pop         (q_pop),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.result_kind   (result_kind),
		.payload_byte  (payload_byte),
		.last_payload  (last_payload),
		.frame_type    (frame_type),
		.frame_ident   (frame_ident),
		.source_address(source_address),
		.payload_length(payload_length),
		.checksum_ok   (checksum_ok)
	);

endmodule
